// ----- hw/rtl/rrtx_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the RRT extend step block.
// No dependencies; imported by rrt_extend_step, rrtx_dp and rrtx_ctrl.
package rrtx_pkg;

	localparam int COORD_W        = 16;
	localparam int STEP_W         = 15;
	localparam int ITER_W         = 12;
	localparam int IDX_W          = 11;
	localparam int ST_W           = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_W          = 16;
	localparam int D2_W           = 34;
	localparam int SQ_IN_W        = D2_W + 16;
	localparam int LEN_W          = SQ_IN_W / 2;
	localparam int NUM_W          = 40;

	localparam int MAX_NODES_DEF      = 2048;
	localparam int OBSTACLE_COUNT_DEF = 4;
	localparam int GOAL_BIAS_DEF      = 10;

	localparam logic [STEP_W-1:0] STEP_RST   = 15'd205;
	localparam logic [STEP_W-1:0] RADIUS_RST = 15'd410;
	localparam logic [STEP_W-1:0] HEIGHT_RST = 15'd4096;
	localparam logic [ITER_W-1:0] LIMIT_RST  = 12'd1000;

	// cylinder axis offset, 0.8 in Q4.12
	localparam logic [COORD_W-1:0] OBS_POS = 16'd3277;
	localparam logic [COORD_W-1:0] OBS_NEG = 16'hF333;

	typedef logic [2:0][COORD_W-1:0] pt_t;

	typedef enum logic [ST_W-1:0] {
		ST_STARTED = 3'd0,
		ST_ADDED   = 3'd1,
		ST_GOAL    = 3'd2,
		ST_COLL    = 3'd3,
		ST_ZERO    = 3'd4,
		ST_LIMIT   = 3'd5,
		ST_DONE    = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GOAL_X = 3'd0,
		CFG_GOAL_Y = 3'd1,
		CFG_GOAL_Z = 3'd2,
		CFG_STEP   = 3'd3,
		CFG_RADIUS = 3'd4,
		CFG_HEIGHT = 3'd5,
		CFG_LIMIT  = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_SET_DONE,
		OP_BEGIN,
		OP_SEARCH,
		OP_SQRT,
		OP_PREP,
		OP_DIV,
		OP_AXIS,
		OP_COLL_CLR,
		OP_COLL,
		OP_STORE,
		OP_APPEND,
		OP_RESP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		status_t    status;
	} cmd_t;

	typedef struct packed {
		logic action;
		logic finished;
		logic full;
		logic limit;
		logic srch_done;
		logic zero_len;
		logic sqrt_done;
		logic div_done;
		logic coll_done;
		logic collided;
		logic near_goal;
	} stat_t;

	function automatic logic signed [COORD_W:0] sdiff(logic [COORD_W-1:0] a,
			logic [COORD_W-1:0] b);
		return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
	endfunction

	function automatic logic [D2_W-1:0] sq17(logic signed [COORD_W:0] d);
		logic signed [D2_W-1:0] w;
		w = D2_W'(d);
		return D2_W'(w * w);
	endfunction

	function automatic logic [COORD_W-1:0] obs_x(logic [1:0] i);
		case (i)
			2'd0:    return OBS_NEG;
			2'd2:    return OBS_POS;
			default: return '0;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] obs_y(logic [1:0] i);
		case (i)
			2'd1:    return OBS_NEG;
			2'd3:    return OBS_POS;
			default: return '0;
		endcase
	endfunction

endpackage

// ----- hw/rtl/rrt_extend_step.sv -----
`timescale 1ns / 1ps
// Top level of the RRT extend step: goal-biased tree growth in Q4.12 space.
// Uses rrtx_pkg, rrtx_ctrl and rrtx_dp.
//
// One input beat either starts a run (action 0: its point becomes node 0) or runs one
// planning iteration (action 1). An iteration aims at the goal registers, except every
// GOAL_BIAS_PERIOD-th iteration, which aims at the sample in the beat. The block scans
// every stored node for the nearest one (strict compare, lowest index wins ties), steps
// step_length toward the target with round-half-away rounding and saturation, rejects
// points inside the fixed vertical cylinders, stores the point, and appends the goal
// once the new point is within one step of it. Each input beat gives exactly one output
// beat with a status code. Items are handled one at a time; a full iteration is paced by
// the node scan (one memory read per cycle through a three-stage compare pipe), the
// square root and three divisions. The result sits in an output register, so the next
// input beat is taken while the previous result is still stalled.
// Configuration writes are taken at any cycle but should only be issued while idle.
module rrt_extend_step #(
	parameter int MAX_NODES        = rrtx_pkg::MAX_NODES_DEF,
	parameter int OBSTACLE_COUNT   = rrtx_pkg::OBSTACLE_COUNT_DEF,
	parameter int GOAL_BIAS_PERIOD = rrtx_pkg::GOAL_BIAS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [rrtx_pkg::COORD_W-1:0]   point_x,
	input  logic [rrtx_pkg::COORD_W-1:0]   point_y,
	input  logic [rrtx_pkg::COORD_W-1:0]   point_z,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rrtx_pkg::ST_W-1:0]      status,
	output logic [rrtx_pkg::IDX_W-1:0]     node_index,
	output logic [rrtx_pkg::COORD_W-1:0]   new_x,
	output logic [rrtx_pkg::COORD_W-1:0]   new_y,
	output logic [rrtx_pkg::COORD_W-1:0]   new_z,
	input  logic                           cfg_we,
	input  logic [rrtx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rrtx_pkg::CFG_W-1:0]     cfg_wdata
);
	import rrtx_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: handshakes and the command schedule of each item
	rrtx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: node memory, search, steering, cylinder test, result register
	rrtx_dp #(
		.MAX_NODES        (MAX_NODES),
		.OBSTACLE_COUNT   (OBSTACLE_COUNT),
		.GOAL_BIAS_PERIOD (GOAL_BIAS_PERIOD)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.action     (action),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.status     (status),
		.node_index (node_index),
		.new_x      (new_x),
		.new_y      (new_y),
		.new_z      (new_z)
	);

endmodule

// ----- hw/rtl/rrtx_sqrt.sv -----
`timescale 1ns / 1ps
// Iterative integer square root, two radicand bits per cycle.
// Depends on nothing but its parameter; used by rrtx_dp.
module rrtx_sqrt #(
	parameter int IN_W = 50
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IN_W-1:0]   din,
	output logic [IN_W/2-1:0] root,
	output logic              done
);
	localparam int OUT_W = IN_W / 2;
	localparam int RW    = OUT_W + 3;
	localparam int CW    = $clog2(OUT_W + 1);

	logic [IN_W-1:0]  v_q;
	logic [RW-1:0]    rem_q;
	logic [OUT_W-1:0] root_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [RW-1:0]    rem_sh;
	logic [RW-1:0]    trial;
	logic             ge;

	assign rem_sh = {rem_q[RW-3:0], v_q[IN_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(OUT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= din;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[IN_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[OUT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ----- hw/rtl/rrtx_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters; used by rrtx_dp.
module rrtx_div #(
	parameter int N_W = 40,
	parameter int D_W = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic [N_W-1:0] quot,
	output logic           done
);
	localparam int CW = $clog2(N_W + 1);

	logic [N_W-1:0] n_q;
	logic [D_W-1:0] d_q;
	logic [D_W-1:0] rem_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [D_W:0]   rem_sh;
	logic [D_W:0]   rem_n;
	logic           ge;

	assign rem_sh = {rem_q, n_q[N_W-1]};
	assign ge     = rem_sh >= {1'b0, d_q};
	assign rem_n  = ge ? rem_sh - {1'b0, d_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(N_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[N_W-2:0], ge};
			rem_q <= rem_n[D_W-1:0];
		end
	end

	assign quot = n_q;
	assign done = done_q;

endmodule

// ----- hw/rtl/rrtx_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the RRT extend step: config registers, node memory, nearest search,
// steering arithmetic, cylinder test and result register. Uses rrtx_pkg, rrtx_sqrt, rrtx_div.
module rrtx_dp #(
	parameter int MAX_NODES        = rrtx_pkg::MAX_NODES_DEF,
	parameter int OBSTACLE_COUNT   = rrtx_pkg::OBSTACLE_COUNT_DEF,
	parameter int GOAL_BIAS_PERIOD = rrtx_pkg::GOAL_BIAS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rrtx_pkg::cmd_t                  cmd,
	output rrtx_pkg::stat_t                 stat,
	input  logic                            action,
	input  logic [rrtx_pkg::COORD_W-1:0]    point_x,
	input  logic [rrtx_pkg::COORD_W-1:0]    point_y,
	input  logic [rrtx_pkg::COORD_W-1:0]    point_z,
	input  logic                            cfg_we,
	input  logic [rrtx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrtx_pkg::CFG_W-1:0]      cfg_wdata,
	output logic [rrtx_pkg::ST_W-1:0]       status,
	output logic [rrtx_pkg::IDX_W-1:0]      node_index,
	output logic [rrtx_pkg::COORD_W-1:0]    new_x,
	output logic [rrtx_pkg::COORD_W-1:0]    new_y,
	output logic [rrtx_pkg::COORD_W-1:0]    new_z
);
	import rrtx_pkg::*;

	localparam int AW    = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int OW    = $clog2(OBSTACLE_COUNT + 1);
	localparam int BW    = $clog2(GOAL_BIAS_PERIOD);

	// configuration
	pt_t               goal_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] radius_q;
	logic [STEP_W-1:0] height_q;
	logic [ITER_W-1:0] limit_q;

	// run state
	logic [CNT_W-1:0]  count_q;
	logic [ITER_W-1:0] iter_q;
	logic              fin_q;
	logic [BW-1:0]     bias_q;

	// item registers
	logic              action_q;
	pt_t               pin_q;
	pt_t               tgt_q;
	pt_t               near_q;
	pt_t               np_q;
	logic [D2_W-1:0]   best_d_q;
	logic [NUM_W-1:0]  num_q;
	logic              neg_q;
	logic [CNT_W-1:0]  idx_q;

	// search pipeline
	logic [CNT_W-1:0]  rd_ptr_q;
	logic              v_s1;
	logic              v_s2;
	pt_t               rd_s1;
	pt_t               pt_s2;
	logic [2:0][D2_W-1:0] sq_s2;

	// cylinder sweep
	logic [OW-1:0]     ocnt_q;
	logic              hit_q;

	// result register
	logic [ST_W-1:0]    res_st_q;
	logic [IDX_W-1:0]   res_idx_q;
	pt_t                res_pt_q;

	logic [2*COORD_W+16-1:0] mem [MAX_NODES];

	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	pt_t               mem_wd;
	logic              issue;
	logic [D2_W-1:0]   d_sum;
	logic [CNT_W-1:0]  last;
	logic [LEN_W-1:0]  len8;
	logic              sqrt_done;
	logic [NUM_W-1:0]  quot;
	logic              div_done;
	logic signed [COORD_W:0] ax_d;
	logic [COORD_W:0]  ax_mag;
	logic [31:0]       ax_prod;
	logic signed [NUM_W+1:0] ax_base;
	logic signed [NUM_W+1:0] ax_q;
	logic signed [NUM_W+1:0] ax_res;
	logic [COORD_W-1:0] ax_sat;
	logic [1:0]        oi;
	logic [D2_W-1:0]   obs_h;
	logic [2*STEP_W-1:0] r2;
	logic              z_in;
	logic              obs_hit;
	logic [D2_W-1:0]   goal_d;
	logic [2*STEP_W-1:0] step2;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q   <= '0;
			step_q   <= STEP_RST;
			radius_q <= RADIUS_RST;
			height_q <= HEIGHT_RST;
			limit_q  <= LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_GOAL_X: goal_q[0] <= cfg_wdata;
				CFG_GOAL_Y: goal_q[1] <= cfg_wdata;
				CFG_GOAL_Z: goal_q[2] <= cfg_wdata;
				CFG_STEP:   step_q    <= cfg_wdata[STEP_W-1:0];
				CFG_RADIUS: radius_q  <= cfg_wdata[STEP_W-1:0];
				CFG_HEIGHT: height_q  <= cfg_wdata[STEP_W-1:0];
				CFG_LIMIT:  limit_q   <= cfg_wdata[ITER_W-1:0];
				default:    ;
			endcase
		end
	end

	// ---------------- node memory ----------------
	always_comb begin
		mem_we = 1'b0;
		mem_wa = count_q[AW-1:0];
		mem_wd = np_q;
		case (cmd.op)
			OP_START: begin
				mem_we = 1'b1;
				mem_wa = '0;
				mem_wd = pin_q;
			end
			OP_STORE: mem_we = 1'b1;
			OP_APPEND: begin
				mem_we = count_q < CNT_W'(MAX_NODES);
				mem_wd = goal_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[rd_ptr_q[AW-1:0]];
	end

	// ---------------- run state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			iter_q  <= '0;
			fin_q   <= 1'b1;
			bias_q  <= '0;
		end else begin
			case (cmd.op)
				OP_START: begin
					count_q <= CNT_W'(1);
					iter_q  <= '0;
					fin_q   <= 1'b0;
					bias_q  <= '0;
				end
				OP_SET_DONE: fin_q <= 1'b1;
				OP_BEGIN: begin
					iter_q <= iter_q + 1'b1;
					bias_q <= (bias_q == BW'(GOAL_BIAS_PERIOD - 1)) ? '0 : bias_q + 1'b1;
				end
				OP_STORE: count_q <= count_q + 1'b1;
				OP_APPEND: begin
					if (count_q < CNT_W'(MAX_NODES))
						count_q <= count_q + 1'b1;
					fin_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// ---------------- nearest search ----------------
	assign issue = (cmd.op == OP_SEARCH) && (rd_ptr_q < count_q);
	assign d_sum = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (cmd.op == OP_BEGIN)
				rd_ptr_q <= '0;
			else if (issue)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++)
			sq_s2[k] <= sq17(sdiff(rd_s1[k], tgt_q[k]));
		pt_s2 <= rd_s1;
		if (cmd.op == OP_BEGIN) begin
			best_d_q <= '1;
		end else if (v_s2 && (d_sum < best_d_q)) begin
			best_d_q <= d_sum;
			near_q   <= pt_s2;
		end
	end

	// ---------------- steering ----------------
	rrtx_sqrt #(
		.IN_W (SQ_IN_W)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_SQRT),
		.din    ({best_d_q, 16'h0000}),
		.root   (len8),
		.done   (sqrt_done)
	);

	rrtx_div #(
		.N_W (NUM_W),
		.D_W (LEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DIV),
		.num    (num_q),
		.den    (len8),
		.quot   (quot),
		.done   (div_done)
	);

	assign ax_d    = sdiff(tgt_q[cmd.axis], near_q[cmd.axis]);
	assign ax_mag  = ax_d[COORD_W] ? (COORD_W+1)'(-ax_d) : ax_d;
	assign ax_prod = 32'(ax_mag) * 32'(step_q);

	// near +/- rounded quotient, then clamp to the coordinate range
	assign ax_base = (NUM_W+2)'($signed(near_q[cmd.axis]));
	assign ax_q    = $signed({2'b00, quot});
	assign ax_res  = neg_q ? ax_base - ax_q : ax_base + ax_q;
	always_comb begin
		if (ax_res > (NUM_W+2)'(32767))
			ax_sat = 16'h7FFF;
		else if (ax_res < -(NUM_W+2)'(32768))
			ax_sat = 16'h8000;
		else
			ax_sat = ax_res[COORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				action_q <= action;
				pin_q    <= {point_z, point_y, point_x};
			end
			OP_BEGIN: tgt_q <= (bias_q == '0) ? pin_q : goal_q;
			OP_PREP: begin
				num_q <= NUM_W'({ax_prod, 8'h00}) + NUM_W'(len8 >> 1);
				neg_q <= ax_d[COORD_W];
			end
			OP_AXIS:  np_q[cmd.axis] <= ax_sat;
			OP_STORE: idx_q <= count_q;
			default: ;
		endcase
	end

	// ---------------- cylinder test ----------------
	assign oi     = 2'(ocnt_q);
	assign obs_h  = sq17(sdiff(np_q[0], obs_x(oi))) + sq17(sdiff(np_q[1], obs_y(oi)));
	assign r2     = radius_q * radius_q;
	assign z_in   = !np_q[2][COORD_W-1] && (np_q[2][COORD_W-2:0] <= height_q);
	assign obs_hit = (obs_h < D2_W'(r2)) && z_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= '0;
			hit_q  <= 1'b0;
		end else if (cmd.op == OP_COLL_CLR) begin
			ocnt_q <= '0;
			hit_q  <= 1'b0;
		end else if (cmd.op == OP_COLL) begin
			ocnt_q <= ocnt_q + 1'b1;
			if (obs_hit)
				hit_q <= 1'b1;
		end
	end

	// ---------------- goal proximity ----------------
	assign goal_d = sq17(sdiff(np_q[0], goal_q[0])) + sq17(sdiff(np_q[1], goal_q[1]))
		+ sq17(sdiff(np_q[2], goal_q[2]));
	assign step2  = step_q * step_q;

	// ---------------- result ----------------
	assign last = (count_q == '0) ? '0 : count_q - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_RESP) begin
			res_st_q <= cmd.status;
			case (cmd.status)
				ST_STARTED: begin
					res_idx_q <= '0;
					res_pt_q  <= pin_q;
				end
				ST_ADDED, ST_GOAL: begin
					res_idx_q <= IDX_W'(idx_q);
					res_pt_q  <= np_q;
				end
				ST_COLL: begin
					res_idx_q <= IDX_W'(last);
					res_pt_q  <= np_q;
				end
				ST_ZERO: begin
					res_idx_q <= IDX_W'(last);
					res_pt_q  <= near_q;
				end
				default: begin
					res_idx_q <= IDX_W'(last);
					res_pt_q  <= '0;
				end
			endcase
		end
	end

	assign status     = res_st_q;
	assign node_index = res_idx_q;
	assign new_x      = res_pt_q[0];
	assign new_y      = res_pt_q[1];
	assign new_z      = res_pt_q[2];

	assign stat.action    = action_q;
	assign stat.finished  = fin_q;
	assign stat.full      = count_q >= CNT_W'(MAX_NODES);
	assign stat.limit     = iter_q >= limit_q;
	assign stat.srch_done = (rd_ptr_q >= count_q) && !v_s1 && !v_s2;
	assign stat.zero_len  = best_d_q == '0;
	assign stat.sqrt_done = sqrt_done;
	assign stat.div_done  = div_done;
	assign stat.coll_done = ocnt_q == OW'(OBSTACLE_COUNT);
	assign stat.collided  = hit_q;
	assign stat.near_goal = goal_d < D2_W'(step2);

endmodule

// ----- hw/rtl/rrtx_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the RRT extend step: handshakes and the per-item command schedule.
// Uses rrtx_pkg; drives rrtx_dp through cmd_t and reads its stat_t.
module rrtx_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  rrtx_pkg::stat_t stat,
	output rrtx_pkg::cmd_t  cmd
);
	import rrtx_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_SEARCH,
		S_CHECK,
		S_SQRT,
		S_PREP,
		S_DIVGO,
		S_DIVW,
		S_CINIT,
		S_COLL,
		S_STORE,
		S_APPEND,
		S_RESP
	} state_t;

	state_t     state_q;
	logic [1:0] axis_q;
	status_t    st_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op     = OP_NONE;
		cmd.axis   = axis_q;
		cmd.status = st_q;
		case (state_q)
			S_IDLE:   if (in_valid) cmd.op = OP_LOAD;
			S_DECIDE: begin
				if (!stat.action)
					cmd.op = OP_START;
				else if (stat.finished)
					cmd.op = OP_NONE;
				else if (stat.full || stat.limit)
					cmd.op = OP_SET_DONE;
				else
					cmd.op = OP_BEGIN;
			end
			S_SEARCH: if (!stat.srch_done) cmd.op = OP_SEARCH;
			S_CHECK:  if (!stat.zero_len) cmd.op = OP_SQRT;
			S_PREP:   cmd.op = OP_PREP;
			S_DIVGO:  cmd.op = OP_DIV;
			S_DIVW:   if (stat.div_done) cmd.op = OP_AXIS;
			S_CINIT:  cmd.op = OP_COLL_CLR;
			S_COLL:   if (!stat.coll_done) cmd.op = OP_COLL;
			S_STORE:  if (!stat.collided) cmd.op = OP_STORE;
			S_APPEND: cmd.op = OP_APPEND;
			S_RESP:   if (slot_free) cmd.op = OP_RESP;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			st_q        <= ST_STARTED;
			out_valid_q <= 1'b0;
		end else begin
			// raise on a new result, drop once the held beat is taken
			if (state_q == S_RESP && slot_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (!stat.action) begin
						st_q    <= ST_STARTED;
						state_q <= S_RESP;
					end else if (stat.finished || stat.full) begin
						st_q    <= ST_DONE;
						state_q <= S_RESP;
					end else if (stat.limit) begin
						st_q    <= ST_LIMIT;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: if (stat.srch_done) state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.zero_len) begin
						st_q    <= ST_ZERO;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (stat.sqrt_done) begin
						axis_q  <= '0;
						state_q <= S_PREP;
					end
				end
				S_PREP:  state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DIVW;
				S_DIVW: begin
					if (stat.div_done) begin
						if (axis_q == 2'd2) begin
							state_q <= S_CINIT;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= S_PREP;
						end
					end
				end
				S_CINIT: state_q <= S_COLL;
				S_COLL:  if (stat.coll_done) state_q <= S_STORE;
				S_STORE: begin
					if (stat.collided) begin
						st_q    <= ST_COLL;
						state_q <= S_RESP;
					end else if (stat.near_goal) begin
						state_q <= S_APPEND;
					end else begin
						st_q    <= ST_ADDED;
						state_q <= S_RESP;
					end
				end
				S_APPEND: begin
					st_q    <= ST_GOAL;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
